[rtl/ibsa_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the bitset algebra block.
package ibsa_pkg;

	localparam int MAX_VALUES_DEF     = 256;
	localparam int MAX_DENSE_SETS_DEF = 1024;
	localparam int BUCKETS_DEF        = 1024;

	localparam int WORD_BITS = 64;
	localparam int OP_W      = 3;
	localparam int ID_W      = 11;
	localparam int VAL_W     = 8;
	localparam int DS_W      = 9;
	localparam int HASH_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int ID_MAX    = 2047;

	localparam logic [HASH_W-1:0] HASH_SEED = 32'h811C_9DC5;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
	localparam logic [OP_W-1:0] OP_UNION = 3'd1;
	localparam logic [OP_W-1:0] OP_INTER = 3'd2;
	localparam logic [OP_W-1:0] OP_DIFF  = 3'd3;
	localparam logic [OP_W-1:0] OP_CONT  = 3'd4;

	// Register index of domain_size
	localparam logic REG_DOMAIN = 1'b0;

	// How a decoded request continues
	typedef enum logic [1:0] {
		DEC_NONE  = 2'd0,
		DEC_IMM   = 2'd1,
		DEC_PROBE = 2'd2,
		DEC_LOAD  = 2'd3
	} dec_t;

	typedef struct packed {
		logic clr_step;
		logic decode;
		logic probe_rd;
		logic probe_fin;
		logic ld_a;
		logic ld_b;
		logic ld_c;
		logic eval;
		logic head_rd;
		logic head_lat;
		logic walk_rd;
		logic walk_lat;
		logic cmp_rd;
		logic cmp_chk;
		logic ins_chk;
		logic ins_wr;
		logic ins_fin;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		dec_t kind;
		logic last_word;
		logic simple;
		logic walk_end;
		logic hash_eq;
		logic word_eq;
		logic full;
		logic out_free;
	} sts_t;

endpackage

[rtl/ibsa_ram.sv]
// Generic single-port RAM with registered read data.
module ibsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[rtl/ibsa_ctrl.sv]
// Controller state machine sequencing the set algebra datapath.
module ibsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          cfg_we,
	input  ibsa_pkg::sts_t sts,
	output ibsa_pkg::cmd_t cmd,
	output logic          in_ready
);

	import ibsa_pkg::*;

	typedef enum logic [18:0] {
		S_CLR  = 19'h00001,
		S_IDLE = 19'h00002,
		S_DEC  = 19'h00004,
		S_PRD  = 19'h00008,
		S_PFIN = 19'h00010,
		S_LA   = 19'h00020,
		S_LB   = 19'h00040,
		S_LC   = 19'h00080,
		S_EVAL = 19'h00100,
		S_HRD  = 19'h00200,
		S_HLAT = 19'h00400,
		S_WALK = 19'h00800,
		S_WLAT = 19'h01000,
		S_CRD  = 19'h02000,
		S_CCHK = 19'h04000,
		S_INS  = 19'h08000,
		S_IWR  = 19'h10000,
		S_IFIN = 19'h20000,
		S_OUT  = 19'h40000
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (accept) state_nx = S_DEC;
			end
			S_DEC: begin
				cmd.decode = 1'b1;
				case (sts.kind)
					DEC_IMM:   state_nx = S_OUT;
					DEC_PROBE: state_nx = S_PRD;
					DEC_LOAD:  state_nx = S_LA;
					default:   state_nx = S_IDLE;
				endcase
			end
			S_PRD: begin
				cmd.probe_rd = 1'b1;
				state_nx     = S_PFIN;
			end
			S_PFIN: begin
				cmd.probe_fin = 1'b1;
				state_nx      = S_OUT;
			end
			S_LA: begin
				cmd.ld_a = 1'b1;
				state_nx = S_LB;
			end
			S_LB: begin
				cmd.ld_b = 1'b1;
				state_nx = S_LC;
			end
			S_LC: begin
				cmd.ld_c = 1'b1;
				state_nx = sts.last_word ? S_EVAL : S_LA;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_nx = sts.simple ? S_OUT : S_HRD;
			end
			S_HRD: begin
				cmd.head_rd = 1'b1;
				state_nx    = S_HLAT;
			end
			S_HLAT: begin
				cmd.head_lat = 1'b1;
				state_nx     = S_WALK;
			end
			S_WALK: begin
				if (sts.walk_end) begin
					state_nx = S_INS;
				end else begin
					cmd.walk_rd = 1'b1;
					state_nx    = S_WLAT;
				end
			end
			S_WLAT: begin
				cmd.walk_lat = 1'b1;
				state_nx     = sts.hash_eq ? S_CRD : S_WALK;
			end
			S_CRD: begin
				cmd.cmp_rd = 1'b1;
				state_nx   = S_CCHK;
			end
			S_CCHK: begin
				cmd.cmp_chk = 1'b1;
				if (!sts.word_eq) begin
					state_nx = S_WALK;
				end else if (sts.last_word) begin
					state_nx = S_OUT;
				end else begin
					state_nx = S_CRD;
				end
			end
			S_INS: begin
				cmd.ins_chk = 1'b1;
				state_nx    = sts.full ? S_OUT : S_IWR;
			end
			S_IWR: begin
				cmd.ins_wr = 1'b1;
				if (sts.last_word) state_nx = S_IFIN;
			end
			S_IFIN: begin
				cmd.ins_fin = 1'b1;
				state_nx    = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_CLR;
		endcase
		if (cfg_we) begin
			cmd      = '0;
			state_nx = S_CLR;
		end
	end

endmodule

[rtl/ibsa_dp.sv]
// Datapath: operand loading, set combination, hash chain lookup and dense table storage.
module ibsa_dp #(
	parameter int MAX_VALUES     = ibsa_pkg::MAX_VALUES_DEF,
	parameter int MAX_DENSE_SETS = ibsa_pkg::MAX_DENSE_SETS_DEF,
	parameter int BUCKETS        = ibsa_pkg::BUCKETS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ibsa_pkg::cmd_t              cmd,
	output ibsa_pkg::sts_t              sts,
	input  logic                        cfg_we,
	input  logic [31:0]                 cfg_wdata,
	output logic [ibsa_pkg::DS_W-1:0]   domain_size,
	input  logic                        accept,
	input  logic [ibsa_pkg::OP_W-1:0]   op,
	input  logic [ibsa_pkg::ID_W-1:0]   left_set,
	input  logic [ibsa_pkg::ID_W-1:0]   right_set,
	input  logic [ibsa_pkg::VAL_W-1:0]  member_value,
	input  logic                        list_last,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [ibsa_pkg::ID_W-1:0]   set_id,
	output logic                        is_member,
	output logic                        status
);

	import ibsa_pkg::*;

	localparam int WORDS   = (MAX_VALUES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIX_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int KW      = (MAX_DENSE_SETS > 1) ? $clog2(MAX_DENSE_SETS) : 1;
	localparam int DC_W    = $clog2(MAX_DENSE_SETS + 1);
	localparam int BW      = $clog2(BUCKETS);
	localparam int SUM_W   = ((DC_W > ID_W) ? DC_W : ID_W) + 1;
	localparam int MW      = WIX_W + 8;
	localparam int DDEPTH  = MAX_DENSE_SETS * (1 << WIX_W);
	localparam int DS_RST  = (MAX_VALUES < 256) ? MAX_VALUES : 256;

	typedef logic [WORD_BITS-1:0] word_t;

	// ---------------- helpers
	function automatic logic [ID_W-1:0] canon(input logic [ID_W-1:0] id,
			input logic [DS_W-1:0] d, input logic [DC_W-1:0] c);
		logic [SUM_W-1:0] t;
		t = SUM_W'(id) - SUM_W'(d) - SUM_W'(1);
		if (id <= ID_W'(d)) return id;
		if (t < SUM_W'(c)) return id;
		return '0;
	endfunction

	function automatic logic [KW-1:0] kidx(input logic [ID_W-1:0] id,
			input logic [DS_W-1:0] d);
		logic [ID_W-1:0] t;
		t = id - ID_W'(d) - ID_W'(1);
		return KW'(t);
	endfunction

	function automatic word_t sword(input logic [ID_W-1:0] id, input logic [WIX_W-1:0] wi);
		logic [ID_W-1:0] v;
		v = id - ID_W'(1);
		if ((v >> 6) == ID_W'(wi)) return word_t'(1) << v[5:0];
		return '0;
	endfunction

	// ---------------- state
	logic [DS_W-1:0]   ds_q;
	logic [DC_W-1:0]   dc_q;
	logic [BW-1:0]     clr_q;
	logic [WIX_W-1:0]  wi_q;
	word_t             work_q [WORDS];
	word_t             cand_q [WORDS];
	logic              m_valid_q;

	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   lraw_q, rraw_q, lc_q, rc_q;
	logic [VAL_W-1:0]  v_q;
	logic              last_q;
	logic [ID_W-1:0]   pid_q, hit_q, miss_q;
	logic [DS_W-1:0]   pval_q;
	logic              pcont_q;
	word_t             lw_q;
	logic [1:0]        cnt_q;
	logic [ID_W-1:0]   first_q;
	logic [HASH_W-1:0] h_q;
	logic [ID_W-1:0]   head_q, cur_q, next_q;
	logic [ID_W-1:0]   res_id_q, out_id_q;
	logic              res_mem_q, res_st_q, out_mem_q, out_st_q;

	// ---------------- memories
	logic [KW+WIX_W-1:0] d_addr;
	logic                d_we;
	word_t               d_rdata;
	logic [BW-1:0]       h_addr;
	logic                h_we;
	logic [ID_W-1:0]     h_wdata, h_rdata;
	logic [KW-1:0]       e_addr;
	logic                e_we;
	logic [HASH_W-1:0]   e_rdata;
	logic [ID_W-1:0]     n_rdata;

	ibsa_ram #(.WIDTH(WORD_BITS), .DEPTH(DDEPTH)) u_dense (
		.clk(clk), .we(d_we), .addr(d_addr), .wdata(cand_q[wi_q]), .rdata(d_rdata));
	ibsa_ram #(.WIDTH(ID_W), .DEPTH(BUCKETS)) u_heads (
		.clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));
	ibsa_ram #(.WIDTH(ID_W), .DEPTH(MAX_DENSE_SETS)) u_next (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(head_q), .rdata(n_rdata));
	ibsa_ram #(.WIDTH(HASH_W), .DEPTH(MAX_DENSE_SETS)) u_ehash (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(h_q), .rdata(e_rdata));

	// ---------------- combinational
	logic [ID_W-1:0]   lc_c, rc_c, new_id;
	logic              last_word;
	logic [WIX_W-1:0]  wi_nx;
	logic [BW-1:0]     bkt;
	logic [BW:0]       bkt_w;
	logic [SUM_W-1:0]  nsum;
	logic              full_c, walk_end_c;
	dec_t              kind_c;
	logic [ID_W-1:0]   imm_id_c, pid_c, hit_c, miss_c;
	logic              imm_mem_c, pcont_c;
	logic [DS_W-1:0]   pval_c;
	word_t             rw_c, x_c, msk_c;
	logic [MW-1:0]     lo_c, dsx_c;
	logic [5:0]        tz_c;

	assign lc_c      = canon(lraw_q, ds_q, dc_q);
	assign rc_c      = canon(rraw_q, ds_q, dc_q);
	assign last_word = (wi_q == WIX_W'(WORDS - 1));
	assign wi_nx     = last_word ? '0 : wi_q + WIX_W'(1);
	assign bkt_w     = {1'b0, h_q[BW-1:0]};
	assign bkt       = (bkt_w >= (BW+1)'(BUCKETS)) ? BW'(bkt_w - (BW+1)'(BUCKETS))
	                                               : h_q[BW-1:0];
	assign nsum      = SUM_W'(ds_q) + SUM_W'(dc_q) + SUM_W'(1);
	assign new_id    = ID_W'(nsum);
	assign full_c    = (SUM_W'(dc_q) >= SUM_W'(MAX_DENSE_SETS)) || (nsum > SUM_W'(ID_MAX));
	assign walk_end_c = (cur_q <= ID_W'(ds_q)) || (canon(cur_q, ds_q, dc_q) == '0);

	// Decode of the latched request
	always_comb begin
		logic sl, sr, vin;
		sl        = (lc_c != '0) && (lc_c <= ID_W'(ds_q));
		sr        = (rc_c != '0) && (rc_c <= ID_W'(ds_q));
		vin       = ({1'b0, v_q} < ds_q);
		kind_c    = DEC_NONE;
		imm_id_c  = '0;
		imm_mem_c = 1'b0;
		pid_c     = '0;
		pval_c    = '0;
		hit_c     = '0;
		miss_c    = '0;
		pcont_c   = 1'b0;
		case (op_q)
			OP_ADD: kind_c = last_q ? DEC_LOAD : DEC_NONE;
			OP_UNION: begin
				kind_c = DEC_IMM;
				if (lc_c == '0) imm_id_c = rc_c;
				else if (rc_c == '0 || lc_c == rc_c) imm_id_c = lc_c;
				else kind_c = DEC_LOAD;
			end
			OP_INTER: begin
				kind_c = DEC_IMM;
				if (lc_c == '0 || rc_c == '0) imm_id_c = '0;
				else if (lc_c == rc_c) imm_id_c = lc_c;
				else if (sl && sr) imm_id_c = '0;
				else if (sl) begin
					kind_c = DEC_PROBE;
					pid_c  = rc_c;
					pval_c = DS_W'(lc_c - ID_W'(1));
					hit_c  = lc_c;
				end else if (sr) begin
					kind_c = DEC_PROBE;
					pid_c  = lc_c;
					pval_c = DS_W'(rc_c - ID_W'(1));
					hit_c  = rc_c;
				end else kind_c = DEC_LOAD;
			end
			OP_DIFF: begin
				kind_c = DEC_IMM;
				if (lc_c == '0 || lc_c == rc_c) imm_id_c = '0;
				else if (rc_c == '0) imm_id_c = lc_c;
				else if (sl && sr) imm_id_c = lc_c;
				else if (sl) begin
					kind_c = DEC_PROBE;
					pid_c  = rc_c;
					pval_c = DS_W'(lc_c - ID_W'(1));
					miss_c = lc_c;
				end else kind_c = DEC_LOAD;
			end
			OP_CONT: begin
				kind_c = DEC_IMM;
				if (!vin || lc_c == '0) imm_mem_c = 1'b0;
				else if (sl) imm_mem_c = (ID_W'(v_q) + ID_W'(1) == lc_c);
				else begin
					kind_c  = DEC_PROBE;
					pid_c   = lc_c;
					pval_c  = DS_W'(v_q);
					pcont_c = 1'b1;
				end
			end
			default: kind_c = DEC_NONE;
		endcase
	end

	// Word combination, domain mask and set-bit index encoder for a word with a single set bit
	always_comb begin
		rw_c = (rc_q == '0) ? '0 : (rc_q <= ID_W'(ds_q)) ? sword(rc_q, wi_q) : d_rdata;
		case (op_q)
			OP_UNION: x_c = lw_q | rw_c;
			OP_INTER: x_c = lw_q & rw_c;
			OP_DIFF:  x_c = lw_q & ~rw_c;
			default:  x_c = work_q[wi_q];
		endcase
		lo_c  = {2'b0, wi_q, 6'b0};
		dsx_c = MW'(ds_q);
		if (dsx_c >= lo_c + MW'(WORD_BITS)) msk_c = '1;
		else if (dsx_c <= lo_c) msk_c = '0;
		else msk_c = {WORD_BITS{1'b1}} >> (7'd64 - 7'(dsx_c - lo_c));
		x_c  = x_c & msk_c;
		tz_c = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (x_c[b]) tz_c = tz_c | 6'(b);
		end
	end

	// Memory port selection
	always_comb begin
		d_we   = cmd.ins_wr;
		d_addr = '0;
		if (cmd.probe_rd) d_addr = {kidx(pid_q, ds_q), WIX_W'(pval_q >> 6)};
		else if (cmd.ld_a) d_addr = {kidx(lc_q, ds_q), wi_q};
		else if (cmd.ld_b) d_addr = {kidx(rc_q, ds_q), wi_q};
		else if (cmd.cmp_rd) d_addr = {kidx(cur_q, ds_q), wi_q};
		else if (cmd.ins_wr) d_addr = {KW'(dc_q), wi_q};
		h_we    = cmd.clr_step | cmd.ins_fin;
		h_addr  = cmd.clr_step ? clr_q : bkt;
		h_wdata = cmd.ins_fin ? new_id : '0;
		e_we    = cmd.ins_fin;
		e_addr  = cmd.ins_fin ? KW'(dc_q) : kidx(cur_q, ds_q);
	end

	always_comb begin
		sts.clr_last  = (clr_q == BW'(BUCKETS - 1));
		sts.kind      = kind_c;
		sts.last_word = last_word;
		sts.simple    = (cnt_q < 2'd2);
		sts.walk_end  = walk_end_c;
		sts.hash_eq   = (e_rdata == h_q);
		sts.word_eq   = (d_rdata == cand_q[wi_q]);
		sts.full      = full_c;
		sts.out_free  = !m_valid_q || out_ready;
	end

	// ---------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ds_q      <= DS_W'(DS_RST);
			dc_q      <= '0;
			clr_q     <= '0;
			wi_q      <= '0;
			m_valid_q <= 1'b0;
			for (int i = 0; i < WORDS; i++) work_q[i] <= '0;
		end else begin
			if (cmd.out_load) m_valid_q <= 1'b1;
			else if (out_ready) m_valid_q <= 1'b0;
			if (cmd.clr_step) clr_q <= clr_q + BW'(1);
			if (cmd.decode || cmd.walk_lat || cmd.ins_chk) wi_q <= '0;
			if (cmd.ld_c || cmd.ins_wr || (cmd.cmp_chk && sts.word_eq)) wi_q <= wi_nx;
			if (cmd.decode && op_q == OP_ADD && {1'b0, v_q} < ds_q)
				work_q[WIX_W'(v_q >> 6)][v_q[5:0]] <= 1'b1;
			if (cmd.ld_c && op_q == OP_ADD) work_q[wi_q] <= '0;
			if (cmd.ins_fin) dc_q <= dc_q + DC_W'(1);
			if (cfg_we) begin
				if (cfg_wdata[DS_W-1:0] == '0) ds_q <= DS_W'(1);
				else if (32'(cfg_wdata[DS_W-1:0]) > 32'(MAX_VALUES)) ds_q <= DS_W'(MAX_VALUES);
				else ds_q <= cfg_wdata[DS_W-1:0];
				dc_q  <= '0;
				clr_q <= '0;
				wi_q  <= '0;
				for (int i = 0; i < WORDS; i++) work_q[i] <= '0;
			end
		end
	end

	// ---------------- payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			lraw_q <= left_set;
			rraw_q <= right_set;
			v_q    <= member_value;
			last_q <= list_last;
		end
		if (cmd.decode) begin
			lc_q      <= lc_c;
			rc_q      <= rc_c;
			pid_q     <= pid_c;
			pval_q    <= pval_c;
			hit_q     <= hit_c;
			miss_q    <= miss_c;
			pcont_q   <= pcont_c;
			res_id_q  <= imm_id_c;
			res_mem_q <= imm_mem_c;
			res_st_q  <= 1'b0;
			cnt_q     <= 2'd0;
			first_q   <= '0;
			h_q       <= HASH_SEED;
		end
		if (cmd.probe_fin) begin
			res_id_q <= d_rdata[pval_q[5:0]] ? hit_q : miss_q;
			if (pcont_q) res_mem_q <= d_rdata[pval_q[5:0]];
		end
		if (cmd.ld_b) begin
			lw_q <= (lc_q == '0) ? '0 : (lc_q <= ID_W'(ds_q)) ? sword(lc_q, wi_q) : d_rdata;
		end
		if (cmd.ld_c) begin
			cand_q[wi_q] <= x_c;
			h_q <= {h_q[26:0], h_q[31:27]} ^ x_c[31:0] ^ x_c[63:32];
			if (x_c != '0) begin
				if (cnt_q == 2'd0) begin
					cnt_q   <= ((x_c & (x_c - word_t'(1))) == '0) ? 2'd1 : 2'd2;
					first_q <= ID_W'({wi_q, tz_c});
				end else begin
					cnt_q <= 2'd2;
				end
			end
		end
		if (cmd.eval) res_id_q <= (cnt_q == 2'd1) ? first_q + ID_W'(1) : '0;
		if (cmd.head_lat) begin
			head_q <= h_rdata;
			cur_q  <= h_rdata;
		end
		if (cmd.walk_lat) begin
			next_q <= n_rdata;
			if (!sts.hash_eq) cur_q <= n_rdata;
		end
		if (cmd.cmp_chk) begin
			if (!sts.word_eq) cur_q <= next_q;
			else if (last_word) res_id_q <= cur_q;
		end
		if (cmd.ins_chk && full_c) begin
			res_id_q <= '0;
			res_st_q <= 1'b1;
		end
		if (cmd.ins_fin) res_id_q <= new_id;
		if (cmd.out_load) begin
			out_id_q  <= res_id_q;
			out_mem_q <= res_mem_q;
			out_st_q  <= res_st_q;
		end
	end

	assign domain_size = ds_q;
	assign out_valid   = m_valid_q;
	assign set_id      = out_id_q;
	assign is_member   = out_mem_q;
	assign status      = out_st_q;

endmodule

[rtl/interned_bitset_algebra_top.sv]
// Top level of the interned bitset set algebra block: ports, register port and unit wiring.
//
//  Channel | Direction | Handshake          | Contents
//  s_*     | in        | s_tvalid/s_tready  | one request: op, operands, value, list end
//  m_*     | out       | m_tvalid/m_tready  | one result: set ID, membership, status
//  APB     | in        | psel/penable       | domain_size register at byte address 0
//
// A request that only adds a value ends with its decode; a shortcut result goes from decode
// to the output, and a membership probe of a dense set first reads one bitmap word. A full
// set operation loads every bitmap word in turn (two reads of the single-port bitmap memory,
// then the combination), then reads the bucket head, reads and hash-checks each chained
// entry, compares each word read back, and writes each word when a new dense set is stored.
// After reset and after each domain_size write the bucket heads are cleared, one bucket per
// cycle, and no request is taken meanwhile. The block handles one request at a time; a
// finished result waits in the output register while the next request is taken.
module interned_bitset_algebra_top #(
	parameter int MAX_VALUES     = ibsa_pkg::MAX_VALUES_DEF,
	parameter int MAX_DENSE_SETS = ibsa_pkg::MAX_DENSE_SETS_DEF,
	parameter int BUCKETS        = ibsa_pkg::BUCKETS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ibsa_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,  // left_set[10:0], right_set[21:11], member_value[29:22]
	input  logic [2:0]                  s_tuser,  // op[2:0]
	input  logic                        s_tlast,  // list_last
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata   // set_id[10:0], is_member[11], status[12]
);

	import ibsa_pkg::*;

	cmd_t            cmd;
	sts_t            sts;
	logic            accept;
	logic            cfg_we;
	logic            in_ready;
	logic [DS_W-1:0] domain_size;
	logic [ID_W-1:0] set_id;
	logic            is_member;
	logic            status;

	// The register port never waits; a write lands in the access cycle.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_DOMAIN);
	assign prdata = (paddr[2] == REG_DOMAIN) ? 32'(domain_size) : '0;

	// A request is taken only while the controller waits in its idle state.
	assign s_tready = in_ready;
	assign accept   = s_tvalid && in_ready;

	ibsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cfg_we   (cfg_we),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	ibsa_dp #(
		.MAX_VALUES     (MAX_VALUES),
		.MAX_DENSE_SETS (MAX_DENSE_SETS),
		.BUCKETS        (BUCKETS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (pwdata),
		.domain_size  (domain_size),
		.accept       (accept),
		.op           (s_tuser),
		.left_set     (s_tdata[10:0]),
		.right_set    (s_tdata[21:11]),
		.member_value (s_tdata[29:22]),
		.list_last    (s_tlast),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.set_id       (set_id),
		.is_member    (is_member),
		.status       (status)
	);

	assign m_tdata = {3'b000, status, is_member, set_id};

endmodule

[sim/tb.sv]
// Self-checking testbench for the interned bitset set algebra block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ibsa_pkg::*;

	localparam int DENSE_CAP   = 1024;
	localparam int STALL_LIMIT = 6000;
	localparam int SETTLE      = 80;

	typedef struct {
		logic [ID_W-1:0] set_id;
		logic            is_member;
		logic            status;
	} set_result_t;

	// Holds its own copy of the domain, the dense table and the list under
	// construction, and predicts the outcome of every accepted request.
	class set_id_scoreboard;
		int unsigned   domain;
		int unsigned   dense_used;
		logic [255:0]  dense_sets [DENSE_CAP];
		logic [255:0]  work_list;
		set_result_t   expected_results [$];
		int unsigned   mismatches;
		int unsigned   results_seen;
		int unsigned   full_reports;

		function new();
			domain = 256;
			clear_table();
		endfunction

		function void clear_table();
			dense_used = 0;
			work_list  = '0;
		endfunction

		function void set_domain(logic [31:0] value);
			int unsigned v;
			v = value & 32'h1FF;
			if (v < 1) v = 1;
			if (v > 256) v = 256;
			domain = v;
			clear_table();
		endfunction

		function int unsigned canon(int unsigned id);
			if (id <= domain) return id;
			if (id - domain - 1 < dense_used) return id;
			return 0;
		endfunction

		function bit is_single(int unsigned id);
			return id != 0 && id <= domain;
		endfunction

		function logic [255:0] bits_of(int unsigned id);
			logic [255:0] w;
			w = '0;
			if (is_single(id)) w[id-1] = 1'b1;
			else if (id != 0) w = dense_sets[id-domain-1];
			return w;
		endfunction

		function bit holds(int unsigned id, int unsigned v);
			if (id == 0 || v >= domain) return 0;
			if (is_single(id)) return id - 1 == v;
			return dense_sets[id-domain-1][v];
		endfunction

		// Canonical ID of a bitmap; a new dense entry is stored when needed.
		function int unsigned canonical_id(logic [255:0] w, output bit full);
			logic [255:0] mask;
			int unsigned  cnt;
			int unsigned  low;
			full = 0;
			mask = {256{1'b1}} >> (256 - domain);
			w    = w & mask;
			cnt  = $countones(w);
			if (cnt == 0) return 0;
			if (cnt == 1) begin
				low = 0;
				while (!w[low]) low++;
				return low + 1;
			end
			for (int k = 0; k < dense_used; k++)
				if (dense_sets[k] == w) return domain + 1 + k;
			if (dense_used >= DENSE_CAP || domain + dense_used + 1 > ID_MAX) begin
				full = 1;
				return 0;
			end
			dense_sets[dense_used] = w;
			dense_used++;
			return domain + dense_used;
		endfunction

		function void note_request(logic [OP_W-1:0] op, int unsigned l_raw, int unsigned r_raw,
				int unsigned v, bit last);
			int unsigned  l;
			int unsigned  r;
			int unsigned  id;
			bit           member;
			bit           full;
			set_result_t  res;
			l = canon(l_raw);
			r = canon(r_raw);
			id = 0;
			member = 0;
			full = 0;
			case (op)
				OP_ADD: begin
					if (v < domain) work_list[v] = 1'b1;
					if (!last) return;
					id = canonical_id(work_list, full);
					work_list = '0;
				end
				OP_UNION: begin
					if (l == 0) id = r;
					else if (r == 0 || l == r) id = l;
					else id = canonical_id(bits_of(l) | bits_of(r), full);
				end
				OP_INTER: begin
					if (l == 0 || r == 0) id = 0;
					else if (l == r) id = l;
					else if (is_single(l)) id = holds(r, l - 1) ? l : 0;
					else if (is_single(r)) id = holds(l, r - 1) ? r : 0;
					else id = canonical_id(bits_of(l) & bits_of(r), full);
				end
				OP_DIFF: begin
					if (l == 0 || l == r) id = 0;
					else if (r == 0) id = l;
					else if (is_single(l)) id = holds(r, l - 1) ? 0 : l;
					else id = canonical_id(bits_of(l) & ~bits_of(r), full);
				end
				OP_CONT: member = holds(l, v);
				default: return;
			endcase
			res.set_id    = id[ID_W-1:0];
			res.is_member = member;
			res.status    = full;
			if (full) full_reports++;
			expected_results.push_back(res);
		endfunction

		function void check_result(logic [15:0] data);
			set_result_t exp_r;
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %h", data);
				return;
			end
			exp_r = expected_results.pop_front();
			if (data[10:0] !== exp_r.set_id || data[11] !== exp_r.is_member ||
					data[12] !== exp_r.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d: expected id %0d member %0b status %0b, got id %0d member %0b status %0b",
						results_seen, exp_r.set_id, exp_r.is_member, exp_r.status,
						data[10:0], data[11], data[12]);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                s_tvalid, s_tready;
	logic [31:0]         s_tdata;
	logic [2:0]          s_tuser;
	logic                s_tlast;
	logic                m_tvalid, m_tready;
	logic [15:0]         m_tdata;

	set_id_scoreboard sb;
	bit               idle_on;
	bit               hold_req;
	int unsigned      requests_sent;
	int unsigned      quiet_cycles;

	interned_bitset_algebra_top u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: random back-pressure, plus one long hold-off on request so that
	// the block's output register fills and the input side has to stall.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 0;
			end
			m_tready = (idle_on && $urandom_range(99) < 34) ? 1'b0 : 1'b1;
		end
	end

	// Result checking and the watchdog, both at the rising edge.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || psel) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// One request: optional idle gap, then hold it until the block takes it.
	task automatic send_request(logic [OP_W-1:0] op, int unsigned l, int unsigned r,
			int unsigned v, bit last);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 34) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tuser  = op;
		s_tdata  = {2'b00, v[VAL_W-1:0], r[ID_W-1:0], l[ID_W-1:0]};
		s_tlast  = last;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, l, r, v, last);
		requests_sent++;
	endtask

	// Lets the block drain: every expected result back, then a settling pause
	// long enough for a request that gives no result.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_domain(logic [31:0] value);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = '0; pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		sb.set_domain(value);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	// Mostly IDs that exist now, sometimes any ID up to 1280.
	function automatic int unsigned pick_id();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 20) return $urandom_range(1280);
		if (roll < 35) return $urandom_range(sb.domain);
		return $urandom_range(sb.domain + sb.dense_used);
	endfunction

	function automatic int unsigned pick_value();
		if ($urandom_range(99) < 85) return $urandom_range(sb.domain - 1);
		return $urandom_range(255);
	endfunction

	// Random mix: list building with interleaved algebra and queries.
	task automatic random_phase(int unsigned count);
		int unsigned roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 35)
				send_request(OP_ADD, $urandom_range(1280), $urandom_range(1280), pick_value(),
					$urandom_range(2) == 0);
			else
				send_request(logic'(0) + OP_W'($urandom_range(OP_CONT, OP_UNION)),
					pick_id(), pick_id(), pick_value(), $urandom_range(1));
		end
	endtask

	initial begin
		int unsigned extra;
		sb = new();
		idle_on = 1; hold_req = 0; requests_sent = 0; quiet_cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = OP_ADD; s_tlast = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset domain of 256 values.
		send_request(OP_ADD, 0, 0, 0, 0);
		send_request(OP_ADD, 0, 0, 255, 1);          // dense {0,255}, first ID 257
		send_request(OP_ADD, 2047, 2047, 7, 1);      // lone value gives its singleton
		send_request(OP_UNION, 1, 256, 0, 0);        // same set found again
		send_request(OP_UNION, 0, 9, 0, 0);          // empty left
		send_request(OP_UNION, 9, 0, 0, 0);          // empty right
		send_request(OP_UNION, 9, 9, 0, 0);          // identical operands
		send_request(OP_UNION, 257, 9, 0, 0);        // new dense set
		send_request(OP_ADD, 0, 0, 64, 0);           // list open across other ops
		send_request(OP_INTER, 258, 257, 0, 0);
		send_request(OP_INTER, 1, 257, 0, 0);        // singleton left inside
		send_request(OP_INTER, 258, 3, 0, 0);        // singleton right outside
		send_request(OP_INTER, 0, 257, 0, 0);
		send_request(OP_INTER, 258, 258, 0, 0);
		send_request(OP_DIFF, 258, 257, 0, 0);
		send_request(OP_DIFF, 9, 258, 0, 0);         // singleton removed
		send_request(OP_DIFF, 9, 257, 0, 0);         // singleton kept
		send_request(OP_DIFF, 257, 0, 0, 0);
		send_request(OP_DIFF, 257, 257, 0, 0);
		send_request(OP_DIFF, 1280, 1, 0, 0);        // unknown ID counts as empty
		send_request(OP_CONT, 258, 0, 8, 0);
		send_request(OP_CONT, 257, 0, 255, 0);
		send_request(OP_CONT, 1280, 0, 3, 0);
		send_request(OP_ADD, 0, 0, 65, 1);           // closes the list {64,65}

		// Random mix under a long receiver hold-off.
		hold_req = 1;
		random_phase(30);
		drain();

		// Smallest domain: only the empty set and one singleton exist.
		write_domain(32'd0);
		random_phase(8);
		drain();

		// Largest written value, clamped to 256.
		write_domain(32'd511);
		random_phase(12);
		drain();

		// Seventy values, ending inside a bitmap word: every pair of singletons is a
		// new dense set, so the table fills to capacity and then reports full.
		write_domain(32'd70);
		idle_on = 0;
		extra = 0;
		for (int a = 1; a < 70 && extra < 4; a++) begin
			for (int b = a + 1; b <= 70 && extra < 4; b++) begin
				if (sb.dense_used >= 300) idle_on = 1;
				if (sb.dense_used >= DENSE_CAP) extra++;
				send_request(OP_UNION, a, b, 0, 0);
			end
		end
		idle_on = 1;
		random_phase(12);
		drain();

		$display("Sent %0d requests and checked %0d results over domains of 256, 1, 256 and 70 values.",
			requests_sent, sb.results_seen);
		$display("The dense table was filled to capacity and %0d full-table reports were seen.",
			sb.full_reports);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches,
				sb.expected_results.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
